FILE: hdl/prpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prpd_pkg
// Shared types, constants and pixel merge functions of the PCX plane decoder.
// ----------------------------------------------------------------------------
package prpd_pkg;

  localparam logic [7:0] RUN_MARK      = 8'hc0;
  localparam logic [5:0] RUN_MASK      = 6'h3f;
  localparam logic [7:0] ONE_BIT_WHITE = 8'd255;
  localparam int         RGB_SHIFT2    = 16;
  localparam int         BYTE_BITS     = 8;

  localparam int GROUP_W  = 64;
  localparam int COUNT_W  = 4;
  localparam int BYTE_W   = 8;
  localparam int PLANE_W  = 2;   // plane index, 0 to 3
  localparam int PLANES_W = 3;   // plane count, 1 to 4
  localparam int RUN_W    = 6;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;
  localparam int BPP_W    = 4;
  localparam int BPL_W    = 13;

  typedef enum logic [1:0] {
    REG_BPP    = 2'd0,
    REG_PLANES = 2'd1,
    REG_BPL    = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    BPP_1,
    BPP_2,
    BPP_4,
    BPP_8
  } bpp_t;

  // Effective configuration as seen by the datapath.
  typedef struct packed {
    bpp_t                bpp;
    logic [PLANES_W-1:0] planes;
    logic                rgb;
    logic                mono;
  } cfg_t;

  // One decode step handed from the sequencer to the merge stage.
  typedef struct packed {
    logic [BYTE_W-1:0]  value;
    logic [PLANE_W-1:0] plane;
    logic               store_wr;
    logic               emit;
    logic               lend;
    logic               last;
  } item_t;

  function automatic logic [COUNT_W-1:0] group_count(input bpp_t bpp, input logic rgb);
    logic [COUNT_W-1:0] c;
    c = 4'd1;
    if (!rgb) begin
      unique case (bpp)
        BPP_1: c = 4'd8;
        BPP_2: c = 4'd4;
        BPP_4: c = 4'd2;
        BPP_8: c = 4'd1;
      endcase
    end
    return c;
  endfunction

  // Merges the plane bytes of one byte position, MSB-first, leftmost pixel low.
  // Planes beyond the plane count must arrive as zero.
  function automatic logic [GROUP_W-1:0] merge_group(input logic [3:0][7:0] b,
                                                     input bpp_t bpp,
                                                     input logic mono);
    logic [GROUP_W-1:0] g;
    logic [7:0]         pix;
    g   = '0;
    pix = '0;
    unique case (bpp)
      BPP_8: g[7:0] = b[0];
      BPP_4: begin
        for (int k = 0; k < 2; k++) begin
          pix = '0;
          for (int p = 0; p < 2; p++) pix[p*4 +: 4] = b[p][(1-k)*4 +: 4];
          g[k*8 +: 8] = pix;
        end
      end
      BPP_2: begin
        for (int k = 0; k < 4; k++) begin
          pix = '0;
          for (int p = 0; p < 4; p++) pix[p*2 +: 2] = b[p][(3-k)*2 +: 2];
          g[k*8 +: 8] = pix;
        end
      end
      BPP_1: begin
        for (int k = 0; k < 8; k++) begin
          pix = '0;
          for (int p = 0; p < 4; p++) pix[p] = b[p][7-k];
          if (mono && pix == 8'd1) pix = ONE_BIT_WHITE;
          g[k*8 +: 8] = pix;
        end
      end
    endcase
    return g;
  endfunction

endpackage

FILE: hdl/prpd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prpd_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module prpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/prpd_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prpd_cfg
// Configuration registers behind the APB-style port, with effective values.
// ----------------------------------------------------------------------------
module prpd_cfg #(
  parameter int MAX_BYTES_PER_LINE = 4096,
  parameter int MAX_PLANES         = 4
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [prpd_pkg::ADDR_W-1:0]           cfg_paddr,
  input  logic [prpd_pkg::DATA_W-1:0]           cfg_pwdata,
  output logic [prpd_pkg::DATA_W-1:0]           cfg_prdata,
  output logic                                  cfg_pready,
  output logic                                  cfg_wr,
  output prpd_pkg::cfg_t                        cfg,
  output logic [$clog2(MAX_BYTES_PER_LINE+1)-1:0] bpl
);
  import prpd_pkg::*;

  localparam int BPLE_W = $clog2(MAX_BYTES_PER_LINE + 1);

  logic [BPP_W-1:0]    bpp_r;
  logic [PLANES_W-1:0] planes_r;
  logic [BPL_W-1:0]    bpl_r;
  reg_idx_t            idx;
  logic [PLANES_W-1:0] planes_eff;

  assign cfg_pready = 1'b1;
  assign idx        = reg_idx_t'(cfg_paddr[ADDR_W-1:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r    <= 4'd8;
      planes_r <= 3'd1;
      bpl_r    <= 13'd1;
    end else if (cfg_wr) begin
      unique case (idx)
        REG_BPP:    bpp_r    <= cfg_pwdata[BPP_W-1:0];
        REG_PLANES: planes_r <= cfg_pwdata[PLANES_W-1:0];
        REG_BPL:    bpl_r    <= cfg_pwdata[BPL_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_BPP:    cfg_prdata = DATA_W'(bpp_r);
      REG_PLANES: cfg_prdata = DATA_W'(planes_r);
      REG_BPL:    cfg_prdata = DATA_W'(bpl_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // Out-of-range plane counts and line lengths are clamped.
  always_comb begin
    if (planes_r == '0) begin
      planes_eff = 3'd1;
    end else if (32'(planes_r) > 32'(MAX_PLANES)) begin
      planes_eff = PLANES_W'(MAX_PLANES);
    end else begin
      planes_eff = planes_r;
    end

    if (bpl_r == '0) begin
      bpl = BPLE_W'(1);
    end else if (32'(bpl_r) > 32'(MAX_BYTES_PER_LINE)) begin
      bpl = BPLE_W'(MAX_BYTES_PER_LINE);
    end else begin
      bpl = BPLE_W'(bpl_r);
    end

    cfg.planes = planes_eff;
    cfg.rgb    = (planes_eff == 3'd3);
    if (cfg.rgb) begin
      cfg.bpp = BPP_8;
    end else begin
      unique case (bpp_r)
        4'd1:    cfg.bpp = BPP_1;
        4'd2:    cfg.bpp = BPP_2;
        4'd4:    cfg.bpp = BPP_4;
        default: cfg.bpp = BPP_8;
      endcase
    end
    cfg.mono = (cfg.bpp == BPP_1) && (planes_eff == 3'd1);
  end

endmodule

FILE: hdl/prpd_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prpd_seq
// Input sequencer: run-length parsing, line position and store read issue.
// ----------------------------------------------------------------------------
module prpd_seq #(
  parameter int MAX_BYTES_PER_LINE = 4096,
  parameter int MAX_PLANES         = 4
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [prpd_pkg::BYTE_W-1:0]            in_byte,
  input  logic                                   cfg_wr,
  input  prpd_pkg::cfg_t                         cfg,
  input  logic [$clog2(MAX_BYTES_PER_LINE+1)-1:0] bpl,
  input  logic                                   iss_ok,
  output logic                                   iss_valid,
  output prpd_pkg::item_t                        iss,
  output logic [((MAX_BYTES_PER_LINE > 1) ? $clog2(MAX_BYTES_PER_LINE) : 1)-1:0] iss_idx
);
  import prpd_pkg::*;

  localparam int IDX_W = (MAX_BYTES_PER_LINE > 1) ? $clog2(MAX_BYTES_PER_LINE) : 1;
  localparam int LINE_MAX = MAX_BYTES_PER_LINE * MAX_PLANES;
  localparam int LP_W  = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
  localparam int M_W   = $clog2(4 * MAX_BYTES_PER_LINE + 1);

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t             state_r;
  logic               await_r;
  logic [RUN_W-1:0]   run_r;
  logic [BYTE_W-1:0]  value_r;
  logic [RUN_W-1:0]   rem_r;
  logic [PLANE_W-1:0] plane_r;
  logic [IDX_W-1:0]   idx_r;
  logic [LP_W-1:0]    lp_r;
  logic               resync_r;

  logic               acc;
  logic               is_mark;
  logic               do_iss;
  logic [BYTE_W-1:0]  iss_val;
  logic [RUN_W-1:0]   iss_rem;
  logic               last_plane;
  logic               idx_end;
  logic               lend;
  logic               clip;
  logic               fin;

  logic [M_W-1:0]     m1, m2, m3, m4, total, lpx, base;
  logic [PLANE_W-1:0] rs_plane;
  logic [IDX_W-1:0]   rs_idx;
  logic [LP_W-1:0]    rs_lp;

  assign in_tready = (state_r == ST_IDLE) && !resync_r && !cfg_wr && iss_ok;
  assign acc       = in_tvalid && in_tready;
  assign is_mark   = (in_byte & RUN_MARK) == RUN_MARK;

  always_comb begin
    do_iss  = 1'b0;
    iss_val = in_byte;
    iss_rem = RUN_W'(1);
    if (state_r == ST_RUN) begin
      do_iss  = iss_ok;
      iss_val = value_r;
      iss_rem = rem_r;
    end else if (acc) begin
      if (await_r) begin
        do_iss  = (run_r != '0);
        iss_rem = run_r;
      end else if (!is_mark) begin
        do_iss = 1'b1;
      end
    end
  end

  // Position bookkeeping for the step being issued.
  always_comb begin
    last_plane = ({1'b0, plane_r} == (cfg.planes - 3'd1));
    idx_end    = (M_W'(idx_r) + M_W'(1)) == M_W'(bpl);
    lend       = last_plane && idx_end;
    clip       = lend || (cfg.rgb && idx_end);
    fin        = clip || (iss_rem == RUN_W'(1));
  end

  assign iss_valid    = do_iss;
  assign iss_idx      = idx_r;
  assign iss.value    = iss_val;
  assign iss.plane    = plane_r;
  assign iss.store_wr = !last_plane;
  assign iss.emit     = last_plane;
  assign iss.lend     = lend;
  assign iss.last     = fin;

  // After a register write the linear line position is split again into
  // plane and byte index under the new line geometry.
  always_comb begin
    m1  = M_W'(bpl);
    m2  = m1 << 1;
    m3  = m1 + m2;
    m4  = m2 << 1;
    lpx = M_W'(lp_r);
    unique case (cfg.planes)
      3'd1:    total = m1;
      3'd2:    total = m2;
      3'd3:    total = m3;
      default: total = m4;
    endcase
    rs_plane = '0;
    base     = '0;
    if (lpx >= m3) begin
      rs_plane = 2'd3;
      base     = m3;
    end else if (lpx >= m2) begin
      rs_plane = 2'd2;
      base     = m2;
    end else if (lpx >= m1) begin
      rs_plane = 2'd1;
      base     = m1;
    end
    rs_idx = IDX_W'(lpx - base);
    rs_lp  = lp_r;
    if (lpx >= total) begin
      rs_plane = '0;
      rs_idx   = '0;
      rs_lp    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      await_r  <= 1'b0;
      run_r    <= '0;
      rem_r    <= '0;
      plane_r  <= '0;
      idx_r    <= '0;
      lp_r     <= '0;
      resync_r <= 1'b0;
    end else begin
      resync_r <= cfg_wr;
      if (resync_r) begin
        plane_r <= rs_plane;
        idx_r   <= rs_idx;
        lp_r    <= rs_lp;
      end
      if (acc) begin
        if (await_r) begin
          await_r <= 1'b0;
          run_r   <= '0;
        end else if (is_mark) begin
          await_r <= 1'b1;
          run_r   <= in_byte[RUN_W-1:0] & RUN_MASK;
        end
      end
      if (do_iss) begin
        if (idx_end) begin
          idx_r   <= '0;
          plane_r <= last_plane ? '0 : plane_r + 2'd1;
        end else begin
          idx_r <= idx_r + IDX_W'(1);
        end
        lp_r    <= lend ? '0 : lp_r + LP_W'(1);
        value_r <= iss_val;
        rem_r   <= iss_rem - RUN_W'(1);
        state_r <= fin ? ST_IDLE : ST_RUN;
      end
    end
  end

  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> !in_tready)
    else $error("input taken while the line position is being rebuilt");

  a_pos_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    !resync_r |-> (({1'b0, plane_r} < cfg.planes) && (M_W'(idx_r) < M_W'(bpl))))
    else $error("line position outside the configured line");

  a_issue_when_ok: assert property (@(posedge clk) disable iff (!rst_n)
    iss_valid |-> iss_ok)
    else $error("decode step issued while the merge stage is blocked");

endmodule

FILE: hdl/prpd_pack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prpd_pack
// Merge stage: plane row write-back with forwarding, pixel packing, output.
// ----------------------------------------------------------------------------
module prpd_pack #(
  parameter int MAX_BYTES_PER_LINE = 4096,
  parameter int MAX_PLANES         = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  prpd_pkg::cfg_t                      cfg,
  input  logic                                iss_valid,
  input  prpd_pkg::item_t                     iss,
  input  logic [((MAX_BYTES_PER_LINE > 1) ? $clog2(MAX_BYTES_PER_LINE) : 1)-1:0] iss_idx,
  output logic                                iss_ok,
  input  logic [((MAX_PLANES > 1) ? MAX_PLANES - 1 : 1)*8-1:0] rd_data,
  output logic                                wr_en,
  output logic [((MAX_BYTES_PER_LINE > 1) ? $clog2(MAX_BYTES_PER_LINE) : 1)-1:0] wr_addr,
  output logic [((MAX_PLANES > 1) ? MAX_PLANES - 1 : 1)*8-1:0] wr_data,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [prpd_pkg::GROUP_W+prpd_pkg::COUNT_W+3:0] out_tdata,
  output logic                                out_tuser,
  output logic                                out_tlast
);
  import prpd_pkg::*;

  localparam int IDX_W = (MAX_BYTES_PER_LINE > 1) ? $clog2(MAX_BYTES_PER_LINE) : 1;
  localparam int LANES = (MAX_PLANES > 1) ? MAX_PLANES - 1 : 1;
  localparam int ROW_W = LANES * 8;
  localparam int TD_W  = GROUP_W + COUNT_W + 4;

  logic               s2_v_r;
  item_t              s2_r;
  logic [IDX_W-1:0]   s2_idx_r;
  logic               s2_hit_r;
  logic [ROW_W-1:0]   s2_fwd_r;

  logic               out_valid_r;
  logic [TD_W-1:0]    out_data_r;
  logic               out_lend_r;
  logic               out_last_r;

  logic               s2_move;
  logic [ROW_W-1:0]   row;
  logic [31:0]        row_ext;
  logic [31:0]        wr_ext;
  logic [3:0][7:0]    b;
  logic [GROUP_W-1:0] group;
  logic [COUNT_W-1:0] count;

  assign s2_move = s2_v_r && (!s2_r.emit || !out_valid_r || out_tready);
  assign iss_ok  = !s2_v_r || s2_move;

  // A row written in the cycle of its read comes from the forward register.
  assign row     = s2_hit_r ? s2_fwd_r : rd_data;
  assign row_ext = 32'(row);

  always_comb begin
    for (int p = 0; p < 4; p++) begin
      if (PLANE_W'(p) == s2_r.plane) begin
        b[p] = s2_r.value;
      end else if (3'(p) < cfg.planes) begin
        b[p] = row_ext[p*8 +: 8];
      end else begin
        b[p] = '0;
      end
    end
    if (cfg.rgb) begin
      group = {40'd0, s2_r.value, row_ext[15:0]};
    end else begin
      group = merge_group(b, cfg.bpp, cfg.mono);
    end
    count  = group_count(cfg.bpp, cfg.rgb);
    wr_ext = row_ext;
    wr_ext[s2_r.plane*8 +: 8] = s2_r.value;
  end

  assign wr_en   = s2_v_r && s2_r.store_wr;
  assign wr_addr = s2_idx_r;
  assign wr_data = ROW_W'(wr_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (iss_ok) begin
        s2_v_r <= iss_valid;
      end
      if (s2_move && s2_r.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (iss_valid && iss_ok) begin
      s2_r     <= iss;
      s2_idx_r <= iss_idx;
      s2_hit_r <= wr_en && (wr_addr == iss_idx);
      s2_fwd_r <= wr_data;
    end
    if (s2_move && s2_r.emit) begin
      out_data_r <= {4'd0, count, group};
      out_lend_r <= s2_r.lend;
      out_last_r <= s2_r.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_lend_r;
  assign out_tlast  = out_last_r;

  a_write_moves: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> s2_move)
    else $error("plane row write from a stalled merge stage");

endmodule

FILE: hdl/pcx_rle_plane_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_rle_plane_decoder_top
// PCX run-length decoder that merges the planes of each scan line into pixels.
// ----------------------------------------------------------------------------
// The block takes the encoded PCX stream one byte per input item (header
// removed). A byte with both top bits set is a run count for the byte after
// it; every other byte is one literal data byte. Data bytes fill the scan line
// plane by plane; the earlier planes are kept in one on-chip RAM of
// MAX_BYTES_PER_LINE rows, one byte lane per stored plane, and every byte of
// the last plane yields one result item holding that byte position's pixels.
// Rate: a literal or a run count byte is taken without holding the sequencer,
// and consecutive literals stream at one per cycle while the merge stage is
// not stalled. A run value byte holds the sequencer busy for each decoded
// byte position, up to 63, ending early where the run is clipped at the end
// of the line (or, with three planes, at the end of a plane). An issued step
// passes through the synchronous row read and then the merge into the output
// register. During a register write, and while the line position is then
// mapped onto the new geometry, no item is taken. The store needs no clearing
// pass after reset.
// ----------------------------------------------------------------------------
module pcx_rle_plane_decoder_top #(
  parameter int MAX_BYTES_PER_LINE = 4096,
  parameter int MAX_PLANES         = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input items. in_tdata: [7:0] code_byte.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,
  // Result items. out_tdata: [63:0] pixel_group, [67:64] pixel_count,
  // [71:68] zero. out_tuser: line_end. out_tlast: last_of_run.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [prpd_pkg::GROUP_W+prpd_pkg::COUNT_W+3:0] out_tdata,
  output logic                                out_tuser,
  output logic                                out_tlast,
  // Configuration: bits_per_pixel at 0x0, plane_count at 0x4,
  // bytes_per_line at 0x8.
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [prpd_pkg::ADDR_W-1:0]         cfg_paddr,
  input  logic [prpd_pkg::DATA_W-1:0]         cfg_pwdata,
  output logic [prpd_pkg::DATA_W-1:0]         cfg_prdata,
  output logic                                cfg_pready
);
  import prpd_pkg::*;

  localparam int IDX_W  = (MAX_BYTES_PER_LINE > 1) ? $clog2(MAX_BYTES_PER_LINE) : 1;
  localparam int LANES  = (MAX_PLANES > 1) ? MAX_PLANES - 1 : 1;
  localparam int ROW_W  = LANES * 8;
  localparam int BPLE_W = $clog2(MAX_BYTES_PER_LINE + 1);

  logic              cfg_wr;
  cfg_t              cfg;
  logic [BPLE_W-1:0] bpl;

  logic              iss_valid;
  item_t             iss;
  logic [IDX_W-1:0]  iss_idx;
  logic              iss_ok;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [ROW_W-1:0]  wr_data;
  logic [ROW_W-1:0]  rd_data;

  prpd_cfg #(
    .MAX_BYTES_PER_LINE (MAX_BYTES_PER_LINE),
    .MAX_PLANES         (MAX_PLANES)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_wr      (cfg_wr),
    .cfg         (cfg),
    .bpl         (bpl)
  );

  // The sequencer parses runs and walks the line; each step it issues reads
  // the stored-plane row at the current byte index.
  prpd_seq #(
    .MAX_BYTES_PER_LINE (MAX_BYTES_PER_LINE),
    .MAX_PLANES         (MAX_PLANES)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .cfg_wr    (cfg_wr),
    .cfg       (cfg),
    .bpl       (bpl),
    .iss_ok    (iss_ok),
    .iss_valid (iss_valid),
    .iss       (iss),
    .iss_idx   (iss_idx)
  );

  // One row per byte index, one byte lane per plane that precedes the last.
  prpd_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_BYTES_PER_LINE)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (iss_valid),
    .rd_addr (iss_idx),
    .rd_data (rd_data)
  );

  // The merge stage either writes its byte back into the row or, on the last
  // plane, combines the row with the new byte into a result item.
  prpd_pack #(
    .MAX_BYTES_PER_LINE (MAX_BYTES_PER_LINE),
    .MAX_PLANES         (MAX_PLANES)
  ) u_pack (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .iss_valid  (iss_valid),
    .iss        (iss),
    .iss_idx    (iss_idx),
    .iss_ok     (iss_ok),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
